// File: hw/rtl/rbge_pkg.sv
// Shared types and constants for the rotary button gesture event block.
package rbge_pkg;

  localparam int unsigned PosW   = 31;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 31;
  localparam int unsigned MaxRes = 4;

  localparam logic [DelayW-1:0] DelayReset = DelayW'(500000);

  typedef enum logic [2:0] {
    EV_TURN    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_RELEASE = 3'd2,
    EV_LONG    = 3'd3,
    EV_CLICK   = 3'd4,
    EV_DOUBLE  = 3'd5
  } ev_kind_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic {
    REG_LONG_PRESS_DELAY = 1'b0,
    REG_CLICK_DELAY      = 1'b1
  } reg_idx_e;

  typedef struct packed {
    ev_kind_e          kind;
    logic [PosW-1:0]   pos;
    logic [TimeW-1:0]  tim;
    logic              last;
  } evt_t;

endpackage

// File: hw/rtl/rotary_button_gesture_events.sv
// Rotary encoder and push-button gesture detector: emits turn, press, release,
// long press, click and double click events from timestamped samples and ticks.
// Each item waits in an input register until the result buffer is empty or its last
// result is leaving; its results (0 to 4) are then written to the four-entry result
// shift buffer, which drains one result per cycle while the output is ready.
// Reset: asynchronous, active low; both delays return to 500000, state to zero.
module rotary_button_gesture_events
  import rbge_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // position[30:0], pressed[31], time_us[63:32]
  input  logic        s_axis_tuser_i,   // opcode
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // event_position[30:0], event_time[62:31], zero[63]
  output logic [2:0]  m_axis_tuser_o,   // event_kind
  output logic        m_axis_tlast_o    // last_of_run
);

  // configuration
  logic [DelayW-1:0] lp_delay_q, ck_delay_q;

  // input register
  logic             in_vld_q;
  op_e              in_op_q;
  logic [PosW-1:0]  in_pos_q;
  logic             in_prs_q;
  logic [TimeW-1:0] in_time_q;

  // gesture state
  logic [PosW-1:0]  last_pos_q, last_pos_d;
  logic             last_prs_q, last_prs_d;
  logic             press_pend_q, press_pend_d;
  logic             rel_pend_q, rel_pend_d;
  logic             armed_q, armed_d;
  logic [TimeW-1:0] lbt_q, lbt_d;

  // result buffer, entry 0 is at the output
  evt_t             buf_q [MaxRes];
  evt_t             slot_d [MaxRes];
  logic [2:0]       cnt_q;
  logic [2:0]       n_res;

  logic             out_hs, buf_free, consume;
  logic [TimeW-1:0] elapsed;
  logic             lp_fire, ck_fire, rel_after, press_after;
  logic             sample, turn, btn, press_ev, rel_ev, dbl;
  evt_t             cand [MaxRes];
  logic [MaxRes-1:0] cand_v;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_delay_q <= DelayReset;
      ck_delay_q <= DelayReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LONG_PRESS_DELAY: lp_delay_q <= cfg_data_i;
        REG_CLICK_DELAY:      ck_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_hs          = m_axis_tvalid_o && m_axis_tready_i;
  assign buf_free        = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_hs);
  assign consume         = in_vld_q && buf_free;
  assign s_axis_tready_o = !in_vld_q || buf_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q   <= op_e'(s_axis_tuser_i);
      in_pos_q  <= s_axis_tdata_i[30:0];
      in_prs_q  <= s_axis_tdata_i[31];
      in_time_q <= s_axis_tdata_i[63:32];
    end
  end

  // gesture evaluation
  always_comb begin
    elapsed     = in_time_q - lbt_q;
    lp_fire     = press_pend_q && (elapsed > {1'b0, lp_delay_q});
    ck_fire     = rel_pend_q && (elapsed > {1'b0, ck_delay_q});
    press_after = press_pend_q && !lp_fire;
    rel_after   = rel_pend_q && !ck_fire;

    sample   = (in_op_q == OP_SAMPLE);
    turn     = sample && (in_pos_q != last_pos_q);
    btn      = sample && (in_prs_q != last_prs_q);
    press_ev = btn && in_prs_q;
    rel_ev   = btn && !in_prs_q;
    dbl      = rel_ev && armed_q;

    armed_d = armed_q;
    if (press_ev && rel_after && (elapsed < {1'b0, ck_delay_q})) armed_d = 1'b1;
    if (dbl) armed_d = 1'b0;

    if (press_ev) begin
      press_pend_d = 1'b1;
      rel_pend_d   = 1'b0;
    end else if (rel_ev) begin
      press_pend_d = 1'b0;
      rel_pend_d   = !armed_q;
    end else begin
      press_pend_d = press_after;
      rel_pend_d   = rel_after;
    end

    lbt_d      = btn ? in_time_q : lbt_q;
    last_pos_d = sample ? in_pos_q : last_pos_q;
    last_prs_d = sample ? in_prs_q : last_prs_q;
  end

  // candidate results in emission order, then packed to the front
  always_comb begin
    cand[0].kind = lp_fire ? EV_LONG : EV_CLICK;
    cand[0].pos  = last_pos_q;
    cand[0].tim  = lbt_q + {1'b0, (lp_fire ? lp_delay_q : ck_delay_q)};
    cand[0].last = 1'b0;
    cand[1].kind = EV_TURN;
    cand[1].pos  = in_pos_q;
    cand[1].tim  = in_time_q;
    cand[1].last = 1'b0;
    cand[2].kind = in_prs_q ? EV_PRESS : EV_RELEASE;
    cand[2].pos  = in_pos_q;
    cand[2].tim  = in_time_q;
    cand[2].last = 1'b0;
    cand[3].kind = EV_DOUBLE;
    cand[3].pos  = in_pos_q;
    cand[3].tim  = in_time_q;
    cand[3].last = 1'b0;
    cand_v = {dbl, btn, turn, lp_fire || ck_fire};

    for (int j = 0; j < MaxRes; j++) slot_d[j] = cand[j];
    n_res = 3'd0;
    for (int i = 0; i < MaxRes; i++) begin
      if (cand_v[i]) begin
        slot_d[n_res[1:0]] = cand[i];
        n_res = n_res + 3'd1;
      end
    end
    if (n_res != 3'd0) slot_d[2'(n_res - 3'd1)].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= '0;
      last_prs_q   <= 1'b0;
      press_pend_q <= 1'b0;
      rel_pend_q   <= 1'b0;
      armed_q      <= 1'b0;
      lbt_q        <= '0;
    end else if (consume) begin
      last_pos_q   <= last_pos_d;
      last_prs_q   <= last_prs_d;
      press_pend_q <= press_pend_d;
      rel_pend_q   <= rel_pend_d;
      armed_q      <= armed_d;
      lbt_q        <= lbt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (consume) begin
      cnt_q <= n_res;
    end else if (out_hs) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // buffer shifts towards entry 0 as results leave
  always_ff @(posedge clk_i) begin
    if (consume) begin
      for (int j = 0; j < MaxRes; j++) buf_q[j] <= slot_d[j];
    end else if (out_hs) begin
      for (int j = 0; j < MaxRes - 1; j++) buf_q[j] <= buf_q[j+1];
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign m_axis_tdata_o  = {1'b0, buf_q[0].tim, buf_q[0].pos};
  assign m_axis_tuser_o  = buf_q[0].kind;
  assign m_axis_tlast_o  = buf_q[0].last;

endmodule
